[rtl/core/msct_pkg.sv]
// Shared types and constants of the multi-slot compare timer scheduler.
package msct_pkg;

  localparam int ID_W     = 4;
  localparam int MODE_W   = 2;
  localparam int RUN_W    = 5;
  localparam int MARGIN_W = 4;
  localparam int CFG_W    = 5;
  localparam int EV_W     = 4;

  localparam logic [MODE_W-1:0] MODE_START   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STOP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPARE = 2'd2;

  localparam logic KIND_EXPIRE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic CFG_MAX_RUNNING = 1'b0;
  localparam logic CFG_NEAR_MARGIN = 1'b1;

  localparam logic [RUN_W-1:0]    MAX_RUNNING_RST = 5'd16;
  localparam logic [MARGIN_W-1:0] NEAR_MARGIN_RST = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_SCAN,
    ST_FLAG,
    ST_STATUS
  } state_e;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    logic wr_en;
    logic stop_en;
    logic tok_shift;
    logic tok_inject;
    logic fire_go;
    logic flag_en;
    logic rebase;
  } cell_cmd_t;

  // Per-cell status back to the sequencer
  typedef struct packed {
    logic sel_running;
    logic hit;
    logic hit_ss;
  } cell_stat_t;

endpackage

[rtl/core/msct_cell.sv]
// One timer slot: slot state, expiry token stage and running-minimum stage.
module msct_cell #(
  parameter int CB  = 24,
  parameter int IDX = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  msct_pkg::cell_cmd_t       cmd_i,
  input  logic [msct_pkg::ID_W-1:0] id_i,
  input  logic [CB-1:0]             ivl_i,
  input  logic                      ss_i,
  input  logic [CB:0]               due_wr_i,
  input  logic [CB-1:0]             now_i,
  input  logic [CB-1:0]             nc_i,
  input  logic [msct_pkg::MARGIN_W-1:0] margin_i,
  input  logic                      tok_i,
  output logic                      tok_o,
  input  logic                      min_valid_i,
  input  logic [CB:0]               min_i,
  output logic                      min_valid_o,
  output logic [CB:0]               min_o,
  output msct_pkg::cell_stat_t      stat_o
);
  import msct_pkg::*;

  localparam logic [31:0] IdxL  = IDX;
  localparam logic [CB:0] Range = {1'b1, {CB{1'b0}}};

  logic          running_q, ss_q, fire_q, tok_q, min_valid_q;
  logic [CB-1:0] ivl_q;
  logic [CB:0]   due_q, min_q;

  logic          sel, act, fire_d, pick_own;
  logic [CB:0]   due_adj, diff, rearm;

  always_comb begin
    sel      = (32'(id_i) == IdxL);
    act      = cmd_i.fire_go & tok_q & running_q & fire_q;
    due_adj  = cmd_i.rebase ? (due_q - Range) : due_q;
    diff     = due_adj - {1'b0, nc_i};
    fire_d   = running_q &&
               ((diff == '0) || (diff < (CB+1)'(margin_i)));
    rearm    = {1'b0, now_i} + {1'b0, ivl_q};
    pick_own = running_q && (!min_valid_i || (due_q < min_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      ss_q        <= 1'b0;
      fire_q      <= 1'b0;
      tok_q       <= 1'b0;
      min_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en && sel) begin
        running_q <= 1'b1;
        ss_q      <= ss_i;
      end else if (cmd_i.stop_en && sel) begin
        running_q <= 1'b0;
        fire_q    <= 1'b0;
      end else if (act) begin
        fire_q <= 1'b0;
        if (ss_q) begin
          running_q <= 1'b0;
        end
      end else if (cmd_i.flag_en) begin
        fire_q <= fire_d;
      end
      if (cmd_i.tok_shift) begin
        tok_q <= tok_i;
      end
      min_valid_q <= pick_own | min_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && sel) begin
      ivl_q <= ivl_i;
      due_q <= due_wr_i;
    end else if (act && !ss_q) begin
      due_q <= rearm;
    end else if (cmd_i.flag_en && cmd_i.rebase && running_q) begin
      due_q <= due_q - Range;
    end
    min_q <= pick_own ? due_q : min_i;
  end

  assign tok_o              = tok_q;
  assign min_valid_o        = min_valid_q;
  assign min_o              = min_q;
  assign stat_o.sel_running = sel & running_q;
  assign stat_o.hit         = tok_q & running_q & fire_q;
  assign stat_o.hit_ss      = tok_q & running_q & fire_q & ss_q;

endmodule

[rtl/core/msct_ctrl.sv]
// Sequencer: item decode, expiry walk, minimum wait, flag update, result register.
module msct_ctrl #(
  parameter int NUM_SLOTS    = 16,
  parameter int COUNTER_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [msct_pkg::MODE_W-1:0]   mode_i,
  input  logic [msct_pkg::ID_W-1:0]     timer_id_i,
  input  logic [COUNTER_BITS-1:0]       interval_i,
  input  logic [COUNTER_BITS-1:0]       counter_now_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          kind_o,
  output logic [msct_pkg::EV_W-1:0]     event_timer_o,
  output logic [COUNTER_BITS-1:0]       compare_value_o,
  output logic                          rejected_o,
  output logic                          start_counter_o,
  output logic [msct_pkg::RUN_W-1:0]    running_count_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [msct_pkg::CFG_W-1:0]    cfg_data_i,
  output msct_pkg::cell_cmd_t           cmd_o,
  output logic [COUNTER_BITS:0]         due_wr_o,
  output logic [COUNTER_BITS-1:0]       now_o,
  output logic [COUNTER_BITS-1:0]       nc_o,
  output logic [msct_pkg::MARGIN_W-1:0] margin_o,
  input  msct_pkg::cell_stat_t          stat_i [NUM_SLOTS],
  input  logic                          min_valid_i,
  input  logic [COUNTER_BITS:0]         min_i
);
  import msct_pkg::*;

  localparam int CB     = COUNTER_BITS;
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int CMP_W  = (CNT_W > RUN_W) ? CNT_W : RUN_W;
  localparam logic [31:0] NumSlotsL = NUM_SLOTS;

  state_e              state_q, state_d;
  logic [RUN_W-1:0]    max_q;
  logic [MARGIN_W-1:0] margin_q;
  logic                started_q, rej_q, start_q, best_any_q;
  logic [CNT_W-1:0]    total_q, cnt_q;
  logic [SLOT_W-1:0]   idx_q;
  logic [CB-1:0]       now_q, nc_q;
  logic [CB:0]         best_q;

  logic                out_valid_q, kind_q, rej_out_q, start_out_q, last_q;
  logic [EV_W-1:0]     ev_q;
  logic [CB-1:0]       cmp_out_q;
  logic [RUN_W-1:0]    run_out_q;

  logic sel_running, hit_any, hit_ss_any;
  logic in_accept, id_ok, limit, start_ok, start_rej, stop_ok, is_cmp;
  logic out_free, step, last_idx, scan_done, load_evt, load_stat;
  logic [31:0] idx_ext, total_ext;

  always_comb begin
    sel_running = 1'b0;
    hit_any     = 1'b0;
    hit_ss_any  = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      sel_running = sel_running | stat_i[i].sel_running;
      hit_any     = hit_any | stat_i[i].hit;
      hit_ss_any  = hit_ss_any | stat_i[i].hit_ss;
    end
  end

  always_comb begin
    in_accept = in_valid_i && (state_q == ST_IDLE);
    id_ok     = (32'(timer_id_i) < NumSlotsL);
    limit     = (CMP_W'(total_q) >= CMP_W'(max_q));
    start_ok  = in_accept && (mode_i == MODE_START) && id_ok && !sel_running && !limit;
    start_rej = in_accept && (mode_i == MODE_START) && id_ok && !sel_running && limit;
    stop_ok   = in_accept && (mode_i == MODE_STOP) && id_ok && sel_running;
    is_cmp    = in_accept && (mode_i == MODE_COMPARE);
    out_free  = !out_valid_q || !out_stall_i;
    step      = !hit_any || out_free;
    last_idx  = (idx_q == SLOT_W'(NUM_SLOTS - 1));
    scan_done = (cnt_q == CNT_W'(NUM_SLOTS));
    idx_ext   = 32'(idx_q);
    total_ext = 32'(total_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (start_ok) begin
            state_d = ST_SCAN;
          end else if (is_cmp) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_STATUS;
          end
        end
      end
      ST_EMIT: begin
        if (step && last_idx) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_FLAG;
        end
      end
      ST_FLAG: begin
        state_d = ST_STATUS;
      end
      ST_STATUS: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_o      = '0;
    load_evt   = 1'b0;
    load_stat  = 1'b0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o       = 1'b0;
        cmd_o.wr_en      = start_ok;
        cmd_o.stop_en    = stop_ok;
        cmd_o.tok_shift  = is_cmp;
        cmd_o.tok_inject = is_cmp;
      end
      ST_EMIT: begin
        cmd_o.tok_shift = step;
        cmd_o.fire_go   = step;
        load_evt        = hit_any && out_free;
      end
      ST_FLAG: begin
        cmd_o.flag_en = 1'b1;
        cmd_o.rebase  = best_any_q && best_q[CB];
      end
      ST_STATUS: begin
        load_stat = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign due_wr_o = started_q ? ({1'b0, counter_now_i} + {1'b0, interval_i})
                              : {1'b0, interval_i};
  assign now_o    = now_q;
  assign nc_o     = best_any_q ? best_q[CB-1:0] : nc_q;
  assign margin_o = margin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      max_q       <= MAX_RUNNING_RST;
      margin_q    <= NEAR_MARGIN_RST;
      started_q   <= 1'b0;
      rej_q       <= 1'b0;
      start_q     <= 1'b0;
      best_any_q  <= 1'b0;
      total_q     <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      nc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_MAX_RUNNING: max_q    <= cfg_data_i;
          CFG_NEAR_MARGIN: margin_q <= cfg_data_i[MARGIN_W-1:0];
          default:         max_q    <= max_q;
        endcase
      end
      if (in_accept) begin
        rej_q     <= start_rej;
        start_q   <= start_ok && !started_q;
        started_q <= started_q | start_ok;
      end
      if (start_ok) begin
        total_q <= total_q + CNT_W'(1);
      end else if (stop_ok || (load_evt && hit_ss_any)) begin
        total_q <= total_q - CNT_W'(1);
      end
      if (is_cmp) begin
        idx_q <= '0;
      end else if ((state_q == ST_EMIT) && step) begin
        idx_q <= idx_q + SLOT_W'(1);
      end
      cnt_q <= (state_q == ST_SCAN) ? cnt_q + CNT_W'(1) : '0;
      if ((state_q == ST_SCAN) && scan_done) begin
        best_any_q <= min_valid_i;
      end
      if (state_q == ST_FLAG) begin
        nc_q <= nc_o;
      end
      if (load_evt || load_stat) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      now_q <= counter_now_i;
    end
    if ((state_q == ST_SCAN) && scan_done) begin
      best_q <= min_i;
    end
    if (load_evt) begin
      kind_q      <= KIND_EXPIRE;
      ev_q        <= idx_ext[EV_W-1:0];
      cmp_out_q   <= '0;
      rej_out_q   <= 1'b0;
      start_out_q <= 1'b0;
      run_out_q   <= '0;
      last_q      <= 1'b0;
    end else if (load_stat) begin
      kind_q      <= KIND_STATUS;
      ev_q        <= '0;
      cmp_out_q   <= nc_q;
      rej_out_q   <= rej_q;
      start_out_q <= start_q;
      run_out_q   <= total_ext[RUN_W-1:0];
      last_q      <= 1'b1;
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign event_timer_o   = ev_q;
  assign compare_value_o = cmp_out_q;
  assign rejected_o      = rej_out_q;
  assign start_counter_o = start_out_q;
  assign running_count_o = run_out_q;
  assign last_o          = last_q;

endmodule

[rtl/core/multi_slot_compare_timer_scheduler_core.sv]
// Top level: sequencer plus a row of timer slot cells.
//
// Multiplexes NUM_SLOTS software timers onto one compare counter.
// Input channel (in_valid_i / in_stall_o): one beat is a start, a stop or a
// compare event. A beat is taken while the block is idle; in_stall_o is high
// while an item is being worked.
// Output channel (out_valid_o / out_stall_i): a compare event gives one
// expiry beat per fired slot in slot order, then a status beat with last_o
// set; every other item gives the status beat alone.
// Sequence: a stop, a refused start or an ignored item goes straight to the
// status beat; an accepted start waits on the minimum chain, which moves one
// cell a cycle; a compare event first walks the expiry token, which visits one
// cell a cycle while the output is not stalled, then waits on the chain.
// A result waits in the output register; while out_stall_i is high the
// token holds on a firing slot and the status beat waits, so no beat is lost.
// Configuration (cfg_valid_i / cfg_ready_o) is always ready; the user must write
// it only while the block is idle, as the block itself does not enforce this.
// Reset clears all slots, the running count, the compare value and the
// counter-started mark, and loads max_running 16 and near_margin 3.
module multi_slot_compare_timer_scheduler_core #(
  parameter int NUM_SLOTS    = 16,
  parameter int COUNTER_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [msct_pkg::MODE_W-1:0] mode_i,
  input  logic [msct_pkg::ID_W-1:0]   timer_id_i,
  input  logic [COUNTER_BITS-1:0]     interval_i,
  input  logic                        single_shot_i,
  input  logic [COUNTER_BITS-1:0]     counter_now_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        kind_o,
  output logic [msct_pkg::EV_W-1:0]   event_timer_o,
  output logic [COUNTER_BITS-1:0]     compare_value_o,
  output logic                        rejected_o,
  output logic                        start_counter_o,
  output logic [msct_pkg::RUN_W-1:0]  running_count_o,
  output logic                        last_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic [msct_pkg::CFG_W-1:0]  cfg_data_i
);
  import msct_pkg::*;

  localparam int CB = COUNTER_BITS;

  cell_cmd_t           cmd;
  cell_stat_t          stat [NUM_SLOTS];
  logic [CB:0]         due_wr;
  logic [CB-1:0]       now, nc;
  logic [MARGIN_W-1:0] margin;
  logic                tok [NUM_SLOTS+1];
  logic                minv [NUM_SLOTS+1];
  logic [CB:0]         minval [NUM_SLOTS+1];
  logic [NUM_SLOTS-1:0] hit_vec;

  msct_ctrl #(
    .NUM_SLOTS   (NUM_SLOTS),
    .COUNTER_BITS(COUNTER_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .timer_id_i     (timer_id_i),
    .interval_i     (interval_i),
    .counter_now_i  (counter_now_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .event_timer_o  (event_timer_o),
    .compare_value_o(compare_value_o),
    .rejected_o     (rejected_o),
    .start_counter_o(start_counter_o),
    .running_count_o(running_count_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_o          (cmd),
    .due_wr_o       (due_wr),
    .now_o          (now),
    .nc_o           (nc),
    .margin_o       (margin),
    .stat_i         (stat),
    .min_valid_i    (minv[NUM_SLOTS]),
    .min_i          (minval[NUM_SLOTS])
  );

  assign tok[0]    = cmd.tok_inject;
  assign minv[0]   = 1'b0;
  assign minval[0] = '0;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    msct_cell #(
      .CB (CB),
      .IDX(g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .id_i       (timer_id_i),
      .ivl_i      (interval_i),
      .ss_i       (single_shot_i),
      .due_wr_i   (due_wr),
      .now_i      (now),
      .nc_i       (nc),
      .margin_i   (margin),
      .tok_i      (tok[g]),
      .tok_o      (tok[g+1]),
      .min_valid_i(minv[g]),
      .min_i      (minval[g]),
      .min_valid_o(minv[g+1]),
      .min_o      (minval[g+1]),
      .stat_o     (stat[g])
    );
    assign hit_vec[g] = stat[g].hit;
  end

  // only one slot can hold the expiry token
  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("more than one slot fires at once");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted without going busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_STATUS) |-> 32'(running_count_o) <= NUM_SLOTS)
    else $error("running count above slot count");

  a_rej_vs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(rejected_o && start_counter_o))
    else $error("start both rejected and taken");

endmodule

[tb/sv/tb_multi_slot_compare_timer_scheduler_core.sv]
// Self-checking testbench for the multi-slot compare timer scheduler core.
module tb_multi_slot_compare_timer_scheduler_core;
  timeunit 1ns;
  timeprecision 1ps;

  import msct_pkg::*;

  localparam int SLOTS = 16;
  localparam int CW = 24;
  localparam logic [CW:0] SPAN = 25'h1000000;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;  // unused encoding, ignored
  localparam int DRAIN_CYCLES = 40;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 67;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   id;
    logic [CW-1:0]     ivl;
    logic              ss;
    logic [CW-1:0]     now;
  } timer_op_t;

  typedef struct packed {
    logic             kind;
    logic [EV_W-1:0]  ev;
    logic [CW-1:0]    cmp;
    logic             rej;
    logic             st;
    logic [RUN_W-1:0] cnt;
    logic             is_last;
  } beat_t;

  typedef enum logic {ROW_OP, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    timer_op_t        op;
    logic             reg_idx;
    logic [CFG_W-1:0] reg_val;
    bit               fixed;
    logic [CW-1:0]    w_cmp;
    logic             w_rej;
    logic             w_st;
    logic [RUN_W-1:0] w_cnt;
  } plan_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [MODE_W-1:0] mode_i = MODE_START;
  logic [ID_W-1:0]   timer_id_i = '0;
  logic [CW-1:0]     interval_i = '0;
  logic              single_shot_i = 1'b0;
  logic [CW-1:0]     counter_now_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              kind_o;
  logic [EV_W-1:0]   event_timer_o;
  logic [CW-1:0]     compare_value_o;
  logic              rejected_o;
  logic              start_counter_o;
  logic [RUN_W-1:0]  running_count_o;
  logic              last_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i = CFG_MAX_RUNNING;
  logic [CFG_W-1:0]  cfg_data_i = '0;

  multi_slot_compare_timer_scheduler_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .timer_id_i      (timer_id_i),
    .interval_i      (interval_i),
    .single_shot_i   (single_shot_i),
    .counter_now_i   (counter_now_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .event_timer_o   (event_timer_o),
    .compare_value_o (compare_value_o),
    .rejected_o      (rejected_o),
    .start_counter_o (start_counter_o),
    .running_count_o (running_count_o),
    .last_o          (last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Scheduler state as the testbench sees it
  logic [SLOTS-1:0] tm_run = '0;
  logic [SLOTS-1:0] tm_ss = '0;
  logic [SLOTS-1:0] tm_fire = '0;
  logic [CW-1:0]    tm_ivl [SLOTS];
  logic [CW:0]      tm_due [SLOTS];
  logic [RUN_W-1:0] tm_active = '0;
  logic [CW-1:0]    tm_cmp = '0;
  logic             tm_started = 1'b0;
  logic [RUN_W-1:0] tm_limit = MAX_RUNNING_RST;
  logic [MARGIN_W-1:0] tm_margin = NEAR_MARGIN_RST;

  beat_t awaited_beats [$];
  int    fail_cnt = 0;
  int    send_gap_pct = 13;
  int    rx_stall_pct = 76;
  bit    rx_hold_req = 1'b0;

  // Directed part. Typed status where it is obvious, predictor elsewhere.
  localparam int PLAN_LEN = 26;
  plan_row_t plan [PLAN_LEN] = '{
    // nothing armed yet: idle stop, early compare, unused mode
    '{ROW_OP, '{MODE_STOP, 4'd5, 24'd0, 1'b0, 24'd0},
      CFG_MAX_RUNNING, 5'd0, 1'b1, 24'd0, 1'b0, 1'b0, 5'd0},
    '{ROW_OP, '{MODE_COMPARE, 4'd0, 24'd0, 1'b0, 24'd0},
      CFG_MAX_RUNNING, 5'd0, 1'b1, 24'd0, 1'b0, 1'b0, 5'd0},
    '{ROW_OP, '{MODE_NONE, 4'd9, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
      CFG_MAX_RUNNING, 5'd0, 1'b1, 24'd0, 1'b0, 1'b0, 5'd0},
    // first start: due is the interval alone, counter gets started
    '{ROW_OP, '{MODE_START, 4'd0, 24'd100, 1'b1, 24'd12345},
      CFG_MAX_RUNNING, 5'd0, 1'b1, 24'd100, 1'b0, 1'b1, 5'd1},
    // restart of a running slot is ignored
    '{ROW_OP, '{MODE_START, 4'd0, 24'd5, 1'b0, 24'd0},
      CFG_MAX_RUNNING, 5'd0, 1'b1, 24'd100, 1'b0, 1'b0, 5'd1},
    '{ROW_OP, '{MODE_START, 4'd15, 24'hFFFFFF, 1'b0, 24'hFFFFFF},
      CFG_MAX_RUNNING, 5'd0, 1'b0, 24'd0, 1'b0, 1'b0, 5'd0},
    '{ROW_OP, '{MODE_START, 4'd1, 24'd0, 1'b0, 24'd98},
      CFG_MAX_RUNNING, 5'd0, 1'b0, 24'd0, 1'b0, 1'b0, 5'd0},
    '{ROW_OP, '{MODE_COMPARE, 4'd0, 24'd0, 1'b0, 24'd98},
      CFG_MAX_RUNNING, 5'd0, 1'b0, 24'd0, 1'b0, 1'b0, 5'd0},
    '{ROW_OP, '{MODE_COMPARE, 4'd0, 24'd0, 1'b0, 24'hFFFFFF},
      CFG_MAX_RUNNING, 5'd0, 1'b0, 24'd0, 1'b0, 1'b0, 5'd0},
    '{ROW_OP, '{MODE_STOP, 4'd1, 24'd0, 1'b0, 24'd0},
      CFG_MAX_RUNNING, 5'd0, 1'b0, 24'd0, 1'b0, 1'b0, 5'd0},
    // earliest due beyond counter range: everything rebased
    '{ROW_OP, '{MODE_COMPARE, 4'd0, 24'd0, 1'b0, 24'h800000},
      CFG_MAX_RUNNING, 5'd0, 1'b0, 24'd0, 1'b0, 1'b0, 5'd0},
    '{ROW_REG, '0, CFG_MAX_RUNNING, 5'd1, 1'b0, 24'd0, 1'b0, 1'b0, 5'd0},
    '{ROW_OP, '{MODE_START, 4'd3, 24'd7, 1'b1, 24'd5},
      CFG_MAX_RUNNING, 5'd0, 1'b0, 24'd0, 1'b0, 1'b0, 5'd0},
    '{ROW_REG, '0, CFG_MAX_RUNNING, 5'd16, 1'b0, 24'd0, 1'b0, 1'b0, 5'd0},
    '{ROW_REG, '0, CFG_NEAR_MARGIN, 5'd0, 1'b0, 24'd0, 1'b0, 1'b0, 5'd0},
    '{ROW_OP, '{MODE_START, 4'd4, 24'd10, 1'b1, 24'hFFFFF0},
      CFG_MAX_RUNNING, 5'd0, 1'b0, 24'd0, 1'b0, 1'b0, 5'd0},
    '{ROW_OP, '{MODE_START, 4'd5, 24'd4, 1'b0, 24'hFFFFF6},
      CFG_MAX_RUNNING, 5'd0, 1'b0, 24'd0, 1'b0, 1'b0, 5'd0},
    '{ROW_OP, '{MODE_COMPARE, 4'd0, 24'd0, 1'b0, 24'hFFFFFA},
      CFG_MAX_RUNNING, 5'd0, 1'b0, 24'd0, 1'b0, 1'b0, 5'd0},
    '{ROW_REG, '0, CFG_NEAR_MARGIN, 5'd15, 1'b0, 24'd0, 1'b0, 1'b0, 5'd0},
    '{ROW_OP, '{MODE_START, 4'd6, 24'd20, 1'b0, 24'hFFFFF0},
      CFG_MAX_RUNNING, 5'd0, 1'b0, 24'd0, 1'b0, 1'b0, 5'd0},
    '{ROW_OP, '{MODE_COMPARE, 4'd0, 24'd0, 1'b0, 24'hFFFFFE},
      CFG_MAX_RUNNING, 5'd0, 1'b0, 24'd0, 1'b0, 1'b0, 5'd0},
    // limit dropped below the running count
    '{ROW_REG, '0, CFG_MAX_RUNNING, 5'd2, 1'b0, 24'd0, 1'b0, 1'b0, 5'd0},
    '{ROW_OP, '{MODE_START, 4'd7, 24'd9, 1'b0, 24'd0},
      CFG_MAX_RUNNING, 5'd0, 1'b0, 24'd0, 1'b0, 1'b0, 5'd0},
    '{ROW_REG, '0, CFG_MAX_RUNNING, 5'd16, 1'b0, 24'd0, 1'b0, 1'b0, 5'd0},
    '{ROW_OP, '{MODE_STOP, 4'd15, 24'd0, 1'b0, 24'd0},
      CFG_MAX_RUNNING, 5'd0, 1'b0, 24'd0, 1'b0, 1'b0, 5'd0},
    '{ROW_OP, '{MODE_STOP, 4'd6, 24'd0, 1'b0, 24'd0},
      CFG_MAX_RUNNING, 5'd0, 1'b0, 24'd0, 1'b0, 1'b0, 5'd0}
  };

  function automatic beat_t status_beat(input logic [CW-1:0] cmp, input logic rej,
                                        input logic st, input logic [RUN_W-1:0] cnt);
    beat_t b;
    b = '{KIND_STATUS, '0, cmp, rej, st, cnt, 1'b1};
    return b;
  endfunction

  // Earliest due, rebase past the counter range, then flag the near slots
  function automatic void pick_next_compare();
    logic        have;
    logic [CW:0] best;
    have = 1'b0;
    best = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (tm_run[i] && (!have || tm_due[i] < best)) begin
        best = tm_due[i];
        have = 1'b1;
      end
    end
    if (have) begin
      if (best[CW]) begin
        best = best - SPAN;
        for (int i = 0; i < SLOTS; i++)
          if (tm_run[i]) tm_due[i] = tm_due[i] - SPAN;
      end
      tm_cmp = best[CW-1:0];
    end
    for (int i = 0; i < SLOTS; i++)
      tm_fire[i] = tm_run[i] && (tm_due[i] == {1'b0, tm_cmp} ||
                   (tm_due[i] > {1'b0, tm_cmp} && tm_due[i] - {1'b0, tm_cmp} < tm_margin));
  endfunction

  function automatic void apply_timer_op(input timer_op_t op);
    logic rej;
    logic st;
    rej = 1'b0;
    st = 1'b0;
    case (op.mode)
      MODE_START: begin
        if (!tm_run[op.id]) begin
          if (tm_active >= tm_limit) begin
            rej = 1'b1;
          end else begin
            tm_ivl[op.id] = op.ivl;
            tm_ss[op.id] = op.ss;
            tm_due[op.id] = tm_started ? {1'b0, op.now} + {1'b0, op.ivl} : {1'b0, op.ivl};
            tm_run[op.id] = 1'b1;
            tm_active++;
            pick_next_compare();
            if (!tm_started) begin
              st = 1'b1;
              tm_started = 1'b1;
            end
          end
        end
      end
      MODE_STOP: begin
        if (tm_run[op.id]) begin
          tm_run[op.id] = 1'b0;
          tm_fire[op.id] = 1'b0;
          tm_active--;
        end
      end
      MODE_COMPARE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tm_run[i] && tm_fire[i]) begin
            tm_fire[i] = 1'b0;
            awaited_beats.push_back('{KIND_EXPIRE, EV_W'(i), '0, 1'b0, 1'b0, '0, 1'b0});
            if (tm_ss[i]) begin
              tm_run[i] = 1'b0;
              tm_active--;
            end else begin
              tm_due[i] = {1'b0, op.now} + {1'b0, tm_ivl[i]};
            end
          end
        end
        pick_next_compare();
      end
      default: ;
    endcase
    awaited_beats.push_back(status_beat(tm_cmp, rej, st, tm_active));
  endfunction

  // Mostly starts near the current compare value and compares at it
  function automatic timer_op_t roll_op();
    timer_op_t op;
    int        r;
    int        k;
    op.mode = MODE_START;
    op.id = ID_W'($urandom_range(SLOTS - 1));
    op.ivl = CW'($urandom);
    op.ss = 1'($urandom_range(1));
    op.now = CW'($urandom);
    r = $urandom_range(99);
    if (r < 4) begin
      op.mode = MODE_NONE;
    end else if (r < 46) begin
      k = $urandom_range(9);
      if (k < 7) op.ivl = CW'($urandom_range(24));
      else if (k < 9) op.ivl = CW'($urandom_range(2000));
      if (tm_started && $urandom_range(6) != 0) op.now = tm_cmp - CW'($urandom_range(8));
    end else if (r < 60) begin
      op.mode = MODE_STOP;
      if ($urandom_range(9) < 7)
        for (k = 0; k < SLOTS && !tm_run[op.id]; k++) op.id = ID_W'($urandom_range(SLOTS - 1));
    end else begin
      op.mode = MODE_COMPARE;
      if ($urandom_range(6) != 0) op.now = tm_cmp;
    end
    return op;
  endfunction

  // Returns at the accepting edge with valid still high
  task automatic offer_item(input timer_op_t op, input bit fixed, input beat_t fixed_beat);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    mode_i <= op.mode;
    timer_id_i <= op.id;
    interval_i <= op.ivl;
    single_shot_i <= op.ss;
    counter_now_i <= op.now;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    apply_timer_op(op);
    if (fixed) begin
      void'(awaited_beats.pop_back());
      awaited_beats.push_back(fixed_beat);
    end
  endtask

  task automatic wait_all_done();
    in_valid_i <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    wait_all_done();
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_MAX_RUNNING) tm_limit = val;
    else tm_margin = val[MARGIN_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic run_phase(input int s_pct, input int r_pct, input logic [RUN_W-1:0] lim,
                           input logic [MARGIN_W-1:0] mrg, input bit pause, input bit hold);
    int sent;
    timer_op_t op;
    sent = 0;
    write_reg(CFG_MAX_RUNNING, lim);
    write_reg(CFG_NEAR_MARGIN, CFG_W'(mrg));
    send_gap_pct = s_pct;
    rx_stall_pct = r_pct;
    while (sent < PHASE_ITEMS) begin
      if (sent == 25 && pause) wait_all_done();
      if (sent == 10 && hold) rx_hold_req = 1'b1;
      op = roll_op();
      offer_item(op, 1'b0, '0);
      if (op.mode != MODE_NONE) sent++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_REG) write_reg(plan[r].reg_idx, plan[r].reg_val);
      else offer_item(plan[r].op, plan[r].fixed,
                      status_beat(plan[r].w_cmp, plan[r].w_rej, plan[r].w_st, plan[r].w_cnt));
    end
    run_phase(13, 76, 5'd16, 4'd15, 1'b0, 1'b0);
    run_phase(76, 13, RUN_W'($urandom_range(2, 8)), MARGIN_W'($urandom_range(1, 14)),
              1'b1, 1'b0);
    run_phase(0, 0, 5'd16, 4'd3, 1'b0, 1'b1);
    in_valid_i <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // Result side stall, with an occasional long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) hold_left--;
      out_stall_i <= (hold_left > 0) || ($urandom_range(99) < rx_stall_pct);
    end
  end

  function automatic string beat_text(input beat_t b);
    return $sformatf("kind=%0d ev=%0d cmp=%06h rej=%0d start=%0d run=%0d last=%0d",
                     b.kind, b.ev, b.cmp, b.rej, b.st, b.cnt, b.is_last);
  endfunction

  always @(posedge clk_i) begin
    beat_t got;
    beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{kind_o, event_timer_o, compare_value_o, rejected_o, start_counter_o,
              running_count_o, last_o};
      if (awaited_beats.size() == 0) begin
        if (fail_cnt < 10) $display("%0t: unexpected beat %s", $realtime, beat_text(got));
        fail_cnt++;
      end else begin
        want = awaited_beats.pop_front();
        if (got !== want) begin
          if (fail_cnt < 10)
            $display("%0t: mismatch\n  exp %s\n  got %s", $realtime, beat_text(want),
                     beat_text(got));
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
